>>> rtl/core/bblc_pkg.sv
// Package of the byte-budget LRU cache: sizes, entry type and control codes.
// It has no dependencies. The cell and top-level modules import it.
package bblc_pkg;

   localparam int ENTRIES         = 16;
   localparam int KEY_BITS        = 64;
   localparam int BYTES_PER_PIXEL = 4;
   localparam int HANDLE_BITS     = 32;
   localparam int DIM_BITS        = 15;
   localparam int BYTES_BITS      = 31;
   localparam int USED_BITS       = 35;
   localparam int MAXB_BITS       = 41;
   localparam int EVICT_BITS      = 5;
   localparam int PROD_BITS       = 2 * DIM_BITS;

   localparam logic [DIM_BITS-1:0]   DIM_MAX         = DIM_BITS'(16384);
   localparam logic [MAXB_BITS-1:0]  MAX_BYTES_RESET = MAXB_BITS'(256 * 1024 * 1024);
   localparam logic [BYTES_BITS-1:0] ENTRY_BYTES_MAX = '1;

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_STORE  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   typedef struct packed {
      logic [KEY_BITS-1:0]    key;
      logic [HANDLE_BITS-1:0] handle;
      logic [BYTES_BITS-1:0]  bytes;
   } entry_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH,
      OP_FRONT,
      OP_REMOVE,
      OP_EVICT,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [KEY_BITS-1:0]  key;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIM,
      ST_OP,
      ST_FIT,
      ST_INSERT,
      ST_DONE
   } state_type;

endpackage

>>> rtl/core/byte_budget_lru_cache.sv
// Byte-budget LRU cache, top level: request sequencer, byte accounting and cell chain.
// Depends on bblc_pkg and bblc_cell.
// One request is handled at a time. A request passes through the accept, budget check,
// operation and result states (a store with a nonzero handle also through fit check
// and insert), with one eviction step per least-recent entry evicted, since the chain
// drops one tail entry per cycle. The configuration port is always
// ready; write the budget only while no request is in flight.
module byte_budget_lru_cache
   import bblc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [MAXB_BITS-1:0]   csr_max_bytes,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_type,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic [HANDLE_BITS-1:0] req_handle,
   input  logic [DIM_BITS-1:0]    req_pixel_width,
   input  logic [DIM_BITS-1:0]    req_pixel_height,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit,
   output logic [HANDLE_BITS-1:0] rsp_handle_out,
   output logic [USED_BITS-1:0]   rsp_bytes_in_use,
   output logic [EVICT_BITS-1:0]  rsp_evicted_count
);

   localparam int SIZE_FULL_BITS = PROD_BITS + 5;

   state_type                state_ff, state_in;
   logic [MAXB_BITS-1:0]     max_ff, max_in;
   logic [USED_BITS-1:0]     used_ff, used_in;
   logic [EVICT_BITS-1:0]    evict_ff, evict_in;
   logic                     hit_ff, hit_in;
   logic [HANDLE_BITS-1:0]   hout_ff, hout_in;
   logic [1:0]               rtype_ff, rtype_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [HANDLE_BITS-1:0]   handle_ff, handle_in;
   logic [DIM_BITS-1:0]      w_ff, w_in, h_ff, h_in;
   logic [BYTES_BITS-1:0]    size_ff, size_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rhit_ff, rhit_in;
   logic [HANDLE_BITS-1:0]   rhout_ff, rhout_in;
   logic [USED_BITS-1:0]     rused_ff, rused_in;
   logic [EVICT_BITS-1:0]    revict_ff, revict_in;

   cell_ctl_type             ctl;
   entry_type                ent       [ENTRIES];
   entry_type                hent      [ENTRIES];
   logic [BYTES_BITS-1:0]    tbytes    [ENTRIES];
   logic [ENTRIES-1:0]       vld_vec;
   logic [ENTRIES-1:0]       match_vec;
   logic [ENTRIES:0]         seen;
   entry_type                hit_or;
   logic [BYTES_BITS-1:0]    tail_or;
   entry_type                front_ent;
   logic [SIZE_FULL_BITS-1:0] size_full;
   logic                     over_budget;
   logic                     no_fit;

   assign seen[0] = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_v, right_v;
      if (i == 0) begin : g_first
         assign left_e = front_ent;
         assign left_v = 1'b1;
      end else begin : g_mid
         assign left_e = ent[i-1];
         assign left_v = vld_vec[i-1];
      end
      if (i == ENTRIES - 1) begin : g_last
         assign right_e = ent[i];
         assign right_v = 1'b0;
      end else begin : g_inner
         assign right_e = ent[i+1];
         assign right_v = vld_vec[i+1];
      end
      bblc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_ent   (left_e),
         .left_vld   (left_v),
         .right_ent  (right_e),
         .right_vld  (right_v),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .match      (match_vec[i]),
         .ent_out    (ent[i]),
         .vld_out    (vld_vec[i]),
         .hit_ent    (hent[i]),
         .tail_bytes (tbytes[i])
      );
   end

   always_comb begin
      hit_or  = '0;
      tail_or = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_or  = hit_or | hent[i];
         tail_or = tail_or | tbytes[i];
      end
   end

   assign size_full   = SIZE_FULL_BITS'(PROD_BITS'(w_ff) * PROD_BITS'(h_ff)) *
                        SIZE_FULL_BITS'(BYTES_PER_PIXEL);
   assign over_budget = MAXB_BITS'(used_ff) > max_ff;
   assign no_fit      = MAXB_BITS'(USED_BITS'(used_ff) + USED_BITS'(size_ff)) > max_ff;

   assign csr_ready         = 1'b1;
   assign req_stall         = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rhit_ff;
   assign rsp_handle_out    = rhout_ff;
   assign rsp_bytes_in_use  = rused_ff;
   assign rsp_evicted_count = revict_ff;

   always_comb begin
      state_in     = state_ff;
      max_in       = max_ff;
      used_in      = used_ff;
      evict_in     = evict_ff;
      hit_in       = hit_ff;
      hout_in      = hout_ff;
      rtype_in     = rtype_ff;
      key_in       = key_ff;
      handle_in    = handle_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      size_in      = size_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rhit_in      = rhit_ff;
      rhout_in     = rhout_ff;
      rused_in     = rused_ff;
      revict_in    = revict_ff;
      ctl.op       = OP_HOLD;
      ctl.key      = key_ff;
      front_ent    = hit_or;

      if (csr_valid && csr_ready) begin
         max_in = csr_max_bytes;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rtype_in  = req_type;
               key_in    = req_key;
               handle_in = req_handle;
               w_in      = (req_pixel_width > DIM_MAX) ? DIM_MAX : req_pixel_width;
               h_in      = (req_pixel_height > DIM_MAX) ? DIM_MAX : req_pixel_height;
               evict_in  = '0;
               hit_in    = 1'b0;
               hout_in   = '0;
               state_in  = ST_TRIM;
            end
         end
         ST_TRIM: begin
            size_in = (size_full > SIZE_FULL_BITS'(ENTRY_BYTES_MAX)) ?
                      ENTRY_BYTES_MAX : size_full[BYTES_BITS-1:0];
            if (over_budget && vld_vec[0]) begin
               ctl.op   = OP_EVICT;
               used_in  = used_ff - USED_BITS'(tail_or);
               evict_in = evict_ff + EVICT_BITS'(1);
            end else begin
               state_in = ST_OP;
            end
         end
         ST_OP: begin
            state_in = ST_DONE;
            case (rtype_ff)
               REQ_LOOKUP: begin
                  if (|match_vec) begin
                     ctl.op  = OP_FRONT;
                     hit_in  = 1'b1;
                     hout_in = hit_or.handle;
                  end
               end
               REQ_STORE: begin
                  if (handle_ff != '0) begin
                     state_in = ST_FIT;
                     if (|match_vec) begin
                        ctl.op  = OP_REMOVE;
                        used_in = used_ff - USED_BITS'(hit_or.bytes);
                     end
                  end
               end
               REQ_CLEAR: begin
                  ctl.op  = OP_CLEAR;
                  used_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_FIT: begin
            if ((no_fit && vld_vec[0]) || vld_vec[ENTRIES-1]) begin
               ctl.op   = OP_EVICT;
               used_in  = used_ff - USED_BITS'(tail_or);
               evict_in = evict_ff + EVICT_BITS'(1);
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            ctl.op           = OP_PUSH;
            front_ent.key    = key_ff;
            front_ent.handle = handle_ff;
            front_ent.bytes  = size_ff;
            used_in          = used_ff + USED_BITS'(size_ff);
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rhit_in      = hit_ff;
               rhout_in     = hout_ff;
               rused_in     = used_ff;
               revict_in    = evict_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      evict_ff  <= evict_in;
      hit_ff    <= hit_in;
      hout_ff   <= hout_in;
      rtype_ff  <= rtype_in;
      key_ff    <= key_in;
      handle_ff <= handle_in;
      w_ff      <= w_in;
      h_ff      <= h_in;
      size_ff   <= size_in;
      rhit_ff   <= rhit_in;
      rhout_ff  <= rhout_in;
      rused_ff  <= rused_in;
      revict_ff <= revict_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_ff       <= MAX_BYTES_RESET;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("More than one valid entry matches the key.");

   a_prefix: assert property (@(posedge clock) disable iff (reset)
      ((vld_vec + 1'b1) & vld_vec) == '0)
      else $error("Valid entries are not packed toward the most recent slot.");

   a_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |-> !vld_vec[ENTRIES-1])
      else $error("Insert started into a full chain.");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_INSERT && !vld_vec[0] |=> used_ff == '0 || vld_vec[0])
      else $error("Byte count is nonzero with an empty chain.");

endmodule

>>> rtl/core/bblc_cell.sv
// One slot of the recency-ordered entry chain; slot 0 holds the most recent entry.
// Depends on bblc_pkg. Instantiated in a row by byte_budget_lru_cache.
module bblc_cell
   import bblc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctl_type           ctl,
   input  entry_type              left_ent,
   input  logic                   left_vld,
   input  entry_type              right_ent,
   input  logic                   right_vld,
   input  logic                   seen_in,
   output logic                   seen_out,
   output logic                   match,
   output entry_type              ent_out,
   output logic                   vld_out,
   output entry_type              hit_ent,
   output logic [BYTES_BITS-1:0]  tail_bytes
);

   entry_type ent_ff, ent_in;
   logic      vld_ff, vld_in;

   assign match      = vld_ff && (ent_ff.key == ctl.key);
   assign seen_out   = seen_in | match;
   assign ent_out    = ent_ff;
   assign vld_out    = vld_ff;
   assign hit_ent    = match ? ent_ff : '0;
   assign tail_bytes = (vld_ff && !right_vld) ? ent_ff.bytes : '0;

   always_comb begin
      ent_in = ent_ff;
      vld_in = vld_ff;
      case (ctl.op)
         OP_PUSH: begin
            ent_in = left_ent;
            vld_in = left_vld;
         end
         OP_FRONT: begin
            if (!seen_in) begin
               ent_in = left_ent;
            end
         end
         OP_REMOVE: begin
            if (seen_in || match) begin
               ent_in = right_ent;
               vld_in = right_vld;
            end
         end
         OP_EVICT: begin
            if (vld_ff && !right_vld) begin
               vld_in = 1'b0;
            end
         end
         OP_CLEAR: begin
            vld_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

endmodule
